// ----- rtl/maf_pkg.sv -----
// ----------------------------------------------------------------------------
// maf_pkg
// Shared widths, defaults and the queue entry type of the moving average filter.
// ----------------------------------------------------------------------------
package maf_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int CFG_W          = 7;
  localparam int DEF_MAX_WINDOW = 64;
  localparam int QDEPTH         = 2;

  localparam logic [CFG_W-1:0] WIN_RESET = 7'd8;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CFG_W-1:0]           win_cfg;
    logic                       rebuild;
  } maf_item_t;

endpackage

// ----- rtl/maf_front.sv -----
// ----------------------------------------------------------------------------
// maf_front
// Input side: holds the window register, tags each beat with the window and a
// rebuild flag after a window change, and queues it for the back end.
// ----------------------------------------------------------------------------
module maf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [maf_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [maf_pkg::CFG_W-1:0]           cfg_window_length,
  output logic                                q_valid,
  output maf_pkg::maf_item_t                  q_item,
  input  logic                                q_pop
);

  localparam int PW = $clog2(maf_pkg::QDEPTH);
  localparam int CW = $clog2(maf_pkg::QDEPTH + 1);

  maf_pkg::maf_item_t          q_r [maf_pkg::QDEPTH];
  logic [PW-1:0]               wp_r;
  logic [PW-1:0]               rp_r;
  logic [CW-1:0]               cnt_r;
  logic [maf_pkg::CFG_W-1:0]   win_cfg_r;
  logic                        pend_r;
  logic                        push;
  maf_pkg::maf_item_t          item;

  assign cfg_ready = 1'b1;
  assign in_ready  = (cnt_r != CW'(maf_pkg::QDEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = q_r[rp_r];
  assign push      = in_valid && in_ready;

  always_comb begin
    item.sample  = in_sample;
    item.win_cfg = win_cfg_r;
    item.rebuild = pend_r;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      rp_r      <= '0;
      cnt_r     <= '0;
      win_cfg_r <= maf_pkg::WIN_RESET;
      pend_r    <= 1'b0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(maf_pkg::QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (q_pop && q_valid) begin
        rp_r <= (rp_r == PW'(maf_pkg::QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !(q_pop && q_valid)) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop && q_valid) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        win_cfg_r <= cfg_window_length;
        pend_r    <= 1'b1;
      end else if (push) begin
        pend_r    <= 1'b0;
      end
    end
  end

endmodule

// ----- rtl/maf_div.sv -----
// ----------------------------------------------------------------------------
// maf_div
// Bit-serial restoring divider, one quotient bit per cycle, truncating toward
// zero, with the output register of the result channel.
// ----------------------------------------------------------------------------
module maf_div #(
  parameter int MAX_WINDOW = maf_pkg::DEF_MAX_WINDOW
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [maf_pkg::SAMPLE_W + $clog2(MAX_WINDOW)-1:0] sum,
  input  logic [$clog2(MAX_WINDOW + 1)-1:0]    win,
  output logic                                 ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [maf_pkg::SAMPLE_W-1:0]  out_average
);

  localparam int SW = maf_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int NW = $clog2(SW);

  logic                               busy_r;
  logic [NW-1:0]                      cnt_r;
  logic                               neg_r;
  logic [SW-1:0]                      q_r;
  logic [WW-1:0]                      rem_r;
  logic [WW-1:0]                      d_r;
  logic                               out_valid_r;
  logic signed [maf_pkg::SAMPLE_W-1:0] out_average_r;
  logic [WW:0]                        t;
  logic [WW:0]                        t_sub;
  logic                               ge;
  logic [SW-1:0]                      q_nxt;
  logic [SW-1:0]                      mag;
  logic [maf_pkg::SAMPLE_W-1:0]       qs;

  assign ready       = !busy_r && !out_valid_r;
  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  always_comb begin
    mag   = sum[SW-1] ? SW'(-sum) : SW'(sum);
    t     = {rem_r, q_r[SW-1]};
    t_sub = t - {1'b0, d_r};
    ge    = (t >= {1'b0, d_r});
    q_nxt = {q_r[SW-2:0], ge};
    qs    = q_nxt[maf_pkg::SAMPLE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (start && ready) begin
        busy_r <= 1'b1;
        cnt_r  <= NW'(SW - 1);
        neg_r  <= sum[SW-1];
        q_r    <= mag;
        rem_r  <= '0;
        d_r    <= win;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= ge ? t_sub[WW-1:0] : t[WW-1:0];
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r        <= 1'b0;
          out_valid_r   <= 1'b1;
          out_average_r <= neg_r ? -qs : qs;
        end
      end
    end
  end

endmodule

// ----- rtl/maf_back.sv -----
// ----------------------------------------------------------------------------
// maf_back
// Back end: sample history ring in memory, running window sum, and a full
// rebuild of the sum over the window after the window length has changed.
// ----------------------------------------------------------------------------
module maf_back #(
  parameter int MAX_WINDOW = maf_pkg::DEF_MAX_WINDOW
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  maf_pkg::maf_item_t                   q_item,
  output logic                                 q_pop,
  input  logic                                 div_ready,
  output logic                                 div_start,
  output logic signed [maf_pkg::SAMPLE_W + $clog2(MAX_WINDOW)-1:0] div_sum,
  output logic [$clog2(MAX_WINDOW + 1)-1:0]    div_win
);

  localparam int SW = maf_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int WW = $clog2(MAX_WINDOW + 1);
  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DW = WW + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_PUSH,
    S_RB_RD,
    S_RB_ACC,
    S_DIV
  } state_t;

  state_t                               state_r;
  logic signed [maf_pkg::SAMPLE_W-1:0]  mem [MAX_WINDOW];
  logic signed [maf_pkg::SAMPLE_W-1:0]  rdata_r;
  logic signed [maf_pkg::SAMPLE_W-1:0]  sample_r;
  logic [WW-1:0]                        win_r;
  logic [AW-1:0]                        wptr_r;
  logic [WW-1:0]                        fill_r;
  logic [WW-1:0]                        cnt_r;
  logic signed [SW-1:0]                 sum_r;
  logic [WW-1:0]                        eff_w;
  logic [WW-1:0]                        off;
  logic [DW-1:0]                        diff;
  logic [AW-1:0]                        raddr;
  logic                                 mem_we;
  logic [AW-1:0]                        wptr_inc;
  logic [WW-1:0]                        fill_inc;
  logic signed [SW-1:0]                 upd_nxt;
  logic signed [SW-1:0]                 acc_nxt;

  always_comb begin
    if (q_item.win_cfg == '0) begin
      eff_w = WW'(1);
    end else if (32'(q_item.win_cfg) > MAX_WINDOW) begin
      eff_w = WW'(MAX_WINDOW);
    end else begin
      eff_w = WW'(q_item.win_cfg);
    end
  end

  // age k sits at wptr - 1 - k
  always_comb begin
    off = (state_r == S_IDLE) ? eff_w : cnt_r + 1'b1;
    diff = DW'(wptr_r) - DW'(off);
    if (diff[DW-1]) begin
      diff = diff + DW'(MAX_WINDOW);
    end
    raddr = diff[AW-1:0];
  end

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign mem_we    = (state_r == S_UPD) || (state_r == S_PUSH);
  assign div_start = (state_r == S_DIV) && div_ready;
  assign div_sum   = sum_r;
  assign div_win   = win_r;
  assign wptr_inc  = (wptr_r == AW'(MAX_WINDOW - 1)) ? '0 : wptr_r + 1'b1;
  assign fill_inc  = (fill_r == WW'(MAX_WINDOW)) ? fill_r : fill_r + 1'b1;
  assign upd_nxt   = sum_r + SW'(sample_r) - ((win_r <= fill_r) ? SW'(rdata_r) : '0);
  assign acc_nxt   = sum_r + ((cnt_r < fill_r) ? SW'(rdata_r) : '0);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wptr_r] <= sample_r;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wptr_r  <= '0;
      fill_r  <= '0;
      sum_r   <= '0;
      cnt_r   <= '0;
      win_r   <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            sample_r <= q_item.sample;
            win_r    <= eff_w;
            state_r  <= q_item.rebuild ? S_PUSH : S_UPD;
          end
        end
        S_UPD: begin
          sum_r   <= upd_nxt;
          wptr_r  <= wptr_inc;
          fill_r  <= fill_inc;
          state_r <= S_DIV;
        end
        S_PUSH: begin
          sum_r   <= '0;
          cnt_r   <= '0;
          wptr_r  <= wptr_inc;
          fill_r  <= fill_inc;
          state_r <= S_RB_RD;
        end
        S_RB_RD: begin
          state_r <= S_RB_ACC;
        end
        S_RB_ACC: begin
          sum_r <= acc_nxt;
          if (cnt_r == win_r - 1'b1) begin
            state_r <= S_DIV;
          end else begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_RB_RD;
          end
        end
        S_DIV: begin
          if (div_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WW'(MAX_WINDOW))
    else $error("history fill count above depth");

  a_upd_to_div: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UPD |=> state_r == S_DIV)
    else $error("running update did not hand off to divider");

  a_pop_path: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_UPD) || (state_r == S_PUSH))
    else $error("popped beat not processed");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> state_r == S_IDLE)
    else $error("back end busy after divider start");

endmodule

// ----- rtl/moving_average_filter_top.sv -----
// ----------------------------------------------------------------------------
// moving_average_filter_top
// Moving average over the newest window_length signed 16-bit samples.
// ----------------------------------------------------------------------------
// Channels: in_* carries one sample per beat, out_* one average per beat,
// cfg_* writes window_length (0 acts as 1, values above MAX_WINDOW clamp).
// Write cfg only while no sample is in flight.
// Each input beat yields exactly one output beat, in order. The average is the
// sum of the newest samples divided by the window, truncated toward zero;
// history slots never written count as zero.
// The divider is bit-serial, one quotient bit per cycle, on a dividend of
// SW = 16 + log2(MAX_WINDOW) bits (22 at the default). The back end prepares
// the next sample's sum while the divider works on the last one. The first
// sample after a window write waits while the sum is rebuilt from the history
// memory, one entry at a time through a read state and an accumulate state.
// A two-beat input queue keeps in_ready high while the back end or a stalled
// output holds a result; a stalled out_ready holds out_average and, once the
// queue is full, drops in_ready.
// Reset (rst_n low, synchronous) empties the history, zeroes the sum and sets
// window_length to 8. No clearing pass is needed.
// ----------------------------------------------------------------------------
module moving_average_filter_top #(
  parameter int MAX_WINDOW = maf_pkg::DEF_MAX_WINDOW
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [maf_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [maf_pkg::SAMPLE_W-1:0] out_average,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [maf_pkg::CFG_W-1:0]           cfg_window_length
);

  localparam int SW = maf_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
  localparam int WW = $clog2(MAX_WINDOW + 1);

  logic                 q_valid;
  logic                 q_pop;
  maf_pkg::maf_item_t   q_item;
  logic                 div_ready;
  logic                 div_start;
  logic signed [SW-1:0] div_sum;
  logic [WW-1:0]        div_win;

  maf_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_window_length (cfg_window_length),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop)
  );

  maf_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .div_ready (div_ready),
    .div_start (div_start),
    .div_sum   (div_sum),
    .div_win   (div_win)
  );

  maf_div #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (div_start),
    .sum         (div_sum),
    .win         (div_win),
    .ready       (div_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_average (out_average)
  );

endmodule

// ----- dv/moving_average_filter_top_tb.sv -----
// ----------------------------------------------------------------------------
// moving_average_filter_top_tb
// Self-checking bench for the moving average filter.
// ----------------------------------------------------------------------------
// A table of directed beats covers the sample extremes, rounding toward zero
// and the window settings 0, 1, 2, 64, 65 and 127. Random phases follow, each
// with its own window length. Every accepted sample updates a local copy of
// the sample history. Each output beat is checked against the table's average
// or else the computed one. Both sides stall at random.
// ----------------------------------------------------------------------------
module moving_average_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_W     = maf_pkg::SAMPLE_W;
  localparam int CFG_W        = maf_pkg::CFG_W;
  localparam int MAX_WINDOW   = maf_pkg::DEF_MAX_WINDOW;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_BEATS  = 75;

  typedef enum logic {ROW_WIN, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [SAMPLE_W-1:0] value;
    logic                known;
    logic [SAMPLE_W-1:0] average;
  } dir_row_t;

  localparam int DIR_ROWS = 29;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_SAMPLE, 16'h7fff, 1'b1, 16'd4095},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'hf000},
    '{ROW_SAMPLE, 16'hffff, 1'b0, 16'd0},
    '{ROW_SAMPLE, 16'h0000, 1'b0, 16'd0},
    '{ROW_WIN,    16'd1,    1'b0, 16'd0},
    '{ROW_SAMPLE, 16'h7fff, 1'b1, 16'h7fff},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, 16'hffff, 1'b1, 16'hffff},
    '{ROW_WIN,    16'd0,    1'b0, 16'd0},
    '{ROW_SAMPLE, 16'h5555, 1'b1, 16'h5555},
    '{ROW_SAMPLE, 16'haaaa, 1'b1, 16'haaaa},
    '{ROW_WIN,    16'd127,  1'b0, 16'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b0, 16'd0},
    '{ROW_SAMPLE, 16'd12345, 1'b0, 16'd0},
    '{ROW_WIN,    16'd65,   1'b0, 16'd0},
    '{ROW_SAMPLE, 16'h7fff, 1'b0, 16'd0},
    '{ROW_WIN,    16'd64,   1'b0, 16'd0},
    '{ROW_SAMPLE, 16'hfff9, 1'b0, 16'd0},
    '{ROW_WIN,    16'd2,    1'b0, 16'd0},
    '{ROW_SAMPLE, 16'd3,    1'b0, 16'd0},
    '{ROW_SAMPLE, 16'hffff, 1'b1, 16'd1},
    '{ROW_SAMPLE, 16'h0000, 1'b1, 16'd0},
    '{ROW_SAMPLE, 16'h8000, 1'b1, 16'hc000},
    '{ROW_SAMPLE, 16'h8001, 1'b1, 16'h8001},
    '{ROW_WIN,    16'd8,    1'b0, 16'd0},
    '{ROW_SAMPLE, 16'd100,  1'b0, 16'd0}
  };

  logic                       clk;
  logic                       rst_n             = 1'b0;
  logic                       in_valid          = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample         = '0;
  logic                       out_valid;
  logic                       out_ready         = 1'b0;
  logic signed [SAMPLE_W-1:0] out_average;
  logic                       cfg_valid         = 1'b0;
  logic                       cfg_ready;
  logic [CFG_W-1:0]           cfg_window_length = '0;

  logic signed [SAMPLE_W-1:0] sample_log [MAX_WINDOW];
  logic [CFG_W-1:0]           window_setting;
  logic signed [SAMPLE_W-1:0] pending_averages [$];
  int                         mismatches = 0;
  int                         hold_left  = 0;
  bit                         quiet_phase = 1'b0;

  moving_average_filter_top #(
    .MAX_WINDOW(MAX_WINDOW)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample        (in_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_average      (out_average),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_window_length(cfg_window_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic int idle_gap();
    int r;
    if (quiet_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // shift the history, rebuild the window sum, divide toward zero
  function automatic logic signed [SAMPLE_W-1:0] push_and_average(
    input logic signed [SAMPLE_W-1:0] s
  );
    int i;
    int span;
    int acc;
    for (i = MAX_WINDOW - 1; i > 0; i--) sample_log[i] = sample_log[i-1];
    sample_log[0] = s;
    span = int'(window_setting);
    if (span < 1) span = 1;
    if (span > MAX_WINDOW) span = MAX_WINDOW;
    acc = 0;
    for (i = 0; i < span; i++) acc += int'(sample_log[i]);
    return SAMPLE_W'(acc / span);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] prev);
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return SAMPLE_W'($urandom_range(0, 15)) - 16'd8;
      3: return prev;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_averages.size() != 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    wait_drained();
    cfg_valid         <= 1'b1;
    cfg_window_length <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid      <= 1'b0;
    window_setting = w;
  endtask

  // valid stays high into the next beat unless a gap is drawn
  task automatic send_sample(
    input logic [SAMPLE_W-1:0] s,
    input logic                known,
    input logic [SAMPLE_W-1:0] typed_avg
  );
    logic signed [SAMPLE_W-1:0] predicted;
    int gap;
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = push_and_average(s);
    pending_averages.push_back(known ? typed_avg : predicted);
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_average(input logic signed [SAMPLE_W-1:0] got);
    logic signed [SAMPLE_W-1:0] want;
    if (pending_averages.size() == 0) begin
      report_mismatch($sformatf("average %0d with no beat pending", got));
    end else begin
      want = pending_averages.pop_front();
      if (got !== want) report_mismatch($sformatf("average %0d, expected %0d", got, want));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_average(out_average);
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= 1'b1;
      hold_left <= idle_gap();
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    dir_row_t            row;
    logic [SAMPLE_W-1:0] last;
    logic [CFG_W-1:0]    w;
    int                  p;
    int                  n;
    for (n = 0; n < MAX_WINDOW; n++) sample_log[n] = '0;
    window_setting = maf_pkg::WIN_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < DIR_ROWS; n++) begin
      row = DIR_TABLE[n];
      if (row.kind == ROW_WIN) write_window(row.value[CFG_W-1:0]);
      else send_sample(row.value, row.known, row.average);
    end

    last = '0;
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: w = 7'd1;
        1: w = 7'd64;
        2: w = 7'd127;
        3: w = 7'd0;
        4: w = CFG_W'($urandom_range(2, 63));
        5: w = CFG_W'($urandom_range(65, 126));
        6: w = 7'd3;
        default: w = CFG_W'($urandom_range(0, 127));
      endcase
      write_window(w);
      quiet_phase = (p == 2) || (p == 6);
      for (n = 0; n < PHASE_BEATS; n++) begin
        if ($urandom_range(0, 49) == 0) wait_drained();
        last = pick_sample(last);
        send_sample(last, 1'b0, '0);
      end
    end

    quiet_phase = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/maf_pkg.sv
rtl/maf_front.sv
rtl/maf_div.sv
rtl/maf_back.sv
rtl/moving_average_filter_top.sv
dv/moving_average_filter_top_tb.sv
